/* src/qbspe_pkg.sv */
// Package with the shared constants, types and register indexes of the B-spline point evaluator.
`timescale 1ns / 1ps

package qbspe_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int COORD_BITS   = 16;
    localparam int U_BITS       = FRAC_BITS + 2;
    localparam int T_BITS       = FRAC_BITS + 1;
    localparam int SQ_BITS      = 2 * FRAC_BITS + 1;
    localparam int W_BITS       = FRAC_BITS + 1;
    localparam int NUM_BITS     = 2 * FRAC_BITS + 3;
    localparam int PROD_BITS    = COORD_BITS + W_BITS + 1;
    localparam int ACC_BITS     = PROD_BITS + 2;
    localparam int CFG_IDX_BITS = 4;
    localparam int N_POINTS     = 4;

    localparam logic [U_BITS-1:0] U_ONE = U_BITS'(1) << FRAC_BITS;
    localparam logic [U_BITS-1:0] U_TWO = U_BITS'(2) << FRAC_BITS;
    localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_POINT0_X = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT0_Y = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT1_X = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT1_Y = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT2_X = CFG_IDX_BITS'(4);
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT2_Y = CFG_IDX_BITS'(5);
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT3_X = CFG_IDX_BITS'(6);
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT3_Y = CFG_IDX_BITS'(7);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [U_BITS-1:0]            t_param;
    typedef logic [W_BITS-1:0]            t_weight;
    typedef logic [CFG_IDX_BITS-1:0]      t_cfg_idx;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef t_point [N_POINTS-1:0] t_points;

    typedef struct packed {
        logic    seg;
        t_weight wa;
        t_weight wb;
        t_weight wc;
    } t_weights;

endpackage

/* src/qbspe_if.sv */
// Interfaces of the parameter, point and configuration channels.
`timescale 1ns / 1ps

interface qbspe_in_if
    import qbspe_pkg::*;
();
    logic   valid;
    logic   ready;
    t_param param_u;

    modport source (output valid, output param_u, input ready);
    modport sink   (input valid, input param_u, output ready);
endinterface

interface qbspe_out_if
    import qbspe_pkg::*;
();
    logic   valid;
    logic   ready;
    t_coord curve_x;
    t_coord curve_y;

    modport source (output valid, output curve_x, output curve_y, input ready);
    modport sink   (input valid, input curve_x, input curve_y, output ready);
endinterface

interface qbspe_cfg_if
    import qbspe_pkg::*;
();
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [COORD_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/qbspe_cfg_regs.sv */
// Control point register file written through the configuration channel.
`timescale 1ns / 1ps

module qbspe_cfg_regs
    import qbspe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_cfg_idx              i_index,
    input  logic [COORD_BITS-1:0] i_data,
    output logic                  o_ready,
    output t_points               o_pts
);

    t_points r_pts;
    t_points n_pts;

    assign o_ready = 1'b1;
    assign o_pts   = r_pts;

    always_comb begin
        n_pts = r_pts;
        if (i_valid) begin
            unique case (i_index)
                REG_POINT0_X: n_pts[0].x = t_coord'(i_data);
                REG_POINT0_Y: n_pts[0].y = t_coord'(i_data);
                REG_POINT1_X: n_pts[1].x = t_coord'(i_data);
                REG_POINT1_Y: n_pts[1].y = t_coord'(i_data);
                REG_POINT2_X: n_pts[2].x = t_coord'(i_data);
                REG_POINT2_Y: n_pts[2].y = t_coord'(i_data);
                REG_POINT3_X: n_pts[3].x = t_coord'(i_data);
                REG_POINT3_Y: n_pts[3].y = t_coord'(i_data);
                default:      n_pts = r_pts;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pts <= '0;
        end else begin
            r_pts <= n_pts;
        end
    end

endmodule

/* src/qbspe_weight.sv */
// Three-stage pipeline that clamps the parameter and forms the three basis weights.
`timescale 1ns / 1ps

module qbspe_weight
    import qbspe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_param   i_u,
    output logic     o_ready,
    output logic     o_valid,
    output t_weights o_w,
    input  logic     i_ready
);

    logic en1, en2, en3;

    logic               r1_v, r1_seg;
    logic [T_BITS-1:0]  r1_t, r1_s;
    logic               n1_seg;
    logic [T_BITS-1:0]  n1_t, n1_s;
    t_param             u_clamp;

    logic               r2_v, r2_seg;
    logic [T_BITS-1:0]  r2_t;
    logic [SQ_BITS-1:0] r2_tt, r2_ss;
    logic [2*T_BITS-1:0] n2_tt_full, n2_ss_full;

    logic               r3_v;
    t_weights           r3_w;
    t_weights           n3_w;
    logic [NUM_BITS-1:0] tt3, lin, num_b, num_a, num_c;

    assign en3     = !r3_v || i_ready;
    assign en2     = !r2_v || en3;
    assign en1     = !r1_v || en2;
    assign o_ready = en1;
    assign o_valid = r3_v;
    assign o_w     = r3_w;

    // Both segments reduce to a local offset t in [0, 1] and its complement s = 1 - t.
    always_comb begin
        u_clamp = (i_u > U_TWO) ? U_TWO : i_u;
        n1_seg  = u_clamp > U_ONE;
        n1_t    = n1_seg ? T_BITS'(u_clamp - U_ONE) : T_BITS'(u_clamp);
        n1_s    = T_ONE - n1_t;
    end

    always_comb begin
        n2_tt_full = r1_t * r1_t;
        n2_ss_full = r1_s * r1_s;
    end

    always_comb begin
        tt3 = NUM_BITS'(r2_tt) + (NUM_BITS'(r2_tt) << 1);
        if (r2_seg) begin
            lin   = (NUM_BITS'(1) << (2 * FRAC_BITS)) + (NUM_BITS'(r2_t) << (FRAC_BITS + 1));
            num_a = NUM_BITS'(r2_ss) + (NUM_BITS'(1) << FRAC_BITS);
            num_c = NUM_BITS'(r2_tt) + (NUM_BITS'(1) << (FRAC_BITS - 1));
        end else begin
            lin   = NUM_BITS'(r2_t) << (FRAC_BITS + 2);
            num_a = NUM_BITS'(r2_ss) + (NUM_BITS'(1) << (FRAC_BITS - 1));
            num_c = NUM_BITS'(r2_tt) + (NUM_BITS'(1) << FRAC_BITS);
        end
        num_b    = lin - tt3 + (NUM_BITS'(1) << FRAC_BITS);
        n3_w.seg = r2_seg;
        n3_w.wb  = W_BITS'(num_b >> (FRAC_BITS + 1));
        if (r2_seg) begin
            n3_w.wa = W_BITS'(num_a >> (FRAC_BITS + 1));
            n3_w.wc = W_BITS'(num_c >> FRAC_BITS);
        end else begin
            n3_w.wa = W_BITS'(num_a >> FRAC_BITS);
            n3_w.wc = W_BITS'(num_c >> (FRAC_BITS + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (en1) begin
                r1_v <= i_valid;
            end
            if (en2) begin
                r2_v <= r1_v;
            end
            if (en3) begin
                r3_v <= r2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r1_seg <= n1_seg;
            r1_t   <= n1_t;
            r1_s   <= n1_s;
        end
        if (en2 && r1_v) begin
            r2_seg <= r1_seg;
            r2_t   <= r1_t;
            r2_tt  <= n2_tt_full[SQ_BITS-1:0];
            r2_ss  <= n2_ss_full[SQ_BITS-1:0];
        end
        if (en3 && r2_v) begin
            r3_w <= n3_w;
        end
    end

endmodule

/* src/qbspe_blend.sv */
// Two-stage pipeline that weights the selected control points, rounds and saturates.
`timescale 1ns / 1ps

module qbspe_blend
    import qbspe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_weights i_w,
    input  t_points  i_pts,
    output logic     o_ready,
    output logic     o_valid,
    output t_coord   o_x,
    output t_coord   o_y,
    input  logic     i_ready
);

    localparam logic signed [ACC_BITS-1:0] ACC_CMAX =
        (ACC_BITS'(1) <<< (COORD_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] ACC_CMIN = ~ACC_CMAX;
    localparam logic signed [ACC_BITS-1:0] ACC_HALF = ACC_BITS'(1) <<< (FRAC_BITS - 1);

    logic en4, en5;

    t_point  c0, c1, c2;
    logic signed [W_BITS:0] sw_a, sw_b, sw_c;

    logic                          r4_v;
    logic signed [PROD_BITS-1:0]   r4_px [3];
    logic signed [PROD_BITS-1:0]   r4_py [3];
    logic signed [PROD_BITS-1:0]   n4_px [3];
    logic signed [PROD_BITS-1:0]   n4_py [3];

    logic        r5_v;
    t_coord      r5_x, r5_y;
    t_coord      n5_x, n5_y;
    logic signed [ACC_BITS-1:0] acc_x, acc_y, sh_x, sh_y;

    assign en5     = !r5_v || i_ready;
    assign en4     = !r4_v || en5;
    assign o_ready = en4;
    assign o_valid = r5_v;
    assign o_x     = r5_x;
    assign o_y     = r5_y;

    always_comb begin
        c0   = i_w.seg ? i_pts[1] : i_pts[0];
        c1   = i_w.seg ? i_pts[2] : i_pts[1];
        c2   = i_w.seg ? i_pts[3] : i_pts[2];
        sw_a = $signed({1'b0, i_w.wa});
        sw_b = $signed({1'b0, i_w.wb});
        sw_c = $signed({1'b0, i_w.wc});
        n4_px[0] = c0.x * sw_a;
        n4_px[1] = c1.x * sw_b;
        n4_px[2] = c2.x * sw_c;
        n4_py[0] = c0.y * sw_a;
        n4_py[1] = c1.y * sw_b;
        n4_py[2] = c2.y * sw_c;
    end

    always_comb begin
        acc_x = ACC_BITS'(r4_px[0]) + ACC_BITS'(r4_px[1]) + ACC_BITS'(r4_px[2]) + ACC_HALF;
        acc_y = ACC_BITS'(r4_py[0]) + ACC_BITS'(r4_py[1]) + ACC_BITS'(r4_py[2]) + ACC_HALF;
        sh_x  = acc_x >>> FRAC_BITS;
        sh_y  = acc_y >>> FRAC_BITS;
        if (sh_x > ACC_CMAX) begin
            n5_x = t_coord'(ACC_CMAX);
        end else if (sh_x < ACC_CMIN) begin
            n5_x = t_coord'(ACC_CMIN);
        end else begin
            n5_x = t_coord'(sh_x);
        end
        if (sh_y > ACC_CMAX) begin
            n5_y = t_coord'(ACC_CMAX);
        end else if (sh_y < ACC_CMIN) begin
            n5_y = t_coord'(ACC_CMIN);
        end else begin
            n5_y = t_coord'(sh_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (en4) begin
                r4_v <= i_valid;
            end
            if (en5) begin
                r5_v <= r4_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && i_valid) begin
            r4_px <= n4_px;
            r4_py <= n4_py;
        end
        if (en5 && r4_v) begin
            r5_x <= n5_x;
            r5_y <= n5_y;
        end
    end

endmodule

/* src/quadratic_bspline_point_eval.sv */
// Quadratic B-spline point evaluator: one curve point per parameter value, fully pipelined.
// The block takes one parameter per clock while the pipeline is not stalled and
// computes its curve point in five register stages (clamp and segment split,
// squaring, weight rounding, coordinate products, sum with rounding and
// saturation). Each stage holds its item under back-pressure, and a stall at the
// output fills any empty stages before the input stops taking transactions.
// Control point writes take effect at once and are to be made while no
// parameter is in flight.
`timescale 1ns / 1ps

module quadratic_bspline_point_eval
    import qbspe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    qbspe_in_if.sink           i_in,
    qbspe_out_if.source        o_res,
    qbspe_cfg_if.sink          i_cfg
);

    t_points  pts;
    logic     w_valid, w_ready;
    t_weights w_data;

    qbspe_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_ready (i_cfg.ready),
        .o_pts   (pts)
    );

    qbspe_weight u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_u     (i_in.param_u),
        .o_ready (i_in.ready),
        .o_valid (w_valid),
        .o_w     (w_data),
        .i_ready (w_ready)
    );

    qbspe_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_w     (w_data),
        .i_pts   (pts),
        .o_ready (w_ready),
        .o_valid (o_res.valid),
        .o_x     (o_res.curve_x),
        .o_y     (o_res.curve_y),
        .i_ready (o_res.ready)
    );

endmodule

/* src/qbspe_checker.sv */
// Port-level checker of the B-spline point evaluator and its binding to the top level.
`timescale 1ns / 1ps

module qbspe_checker
    import qbspe_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_res_valid,
    input logic   i_res_ready,
    input t_coord i_res_x,
    input t_coord i_res_y,
    input logic   i_cfg_ready
);

    // A reset empties the pipeline, so the input is open and no point is offered.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in_ready && !i_res_valid))
        else $error("pipeline not empty after reset");

    // Nothing upstream can stall while the output side takes points.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_ready |-> i_in_ready)
        else $error("input stalled while output is ready");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_x) && $stable(i_res_y)))
        else $error("stalled point changed or dropped");

    // Control point writes are never refused.
    a_cfg_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> i_cfg_ready)
        else $error("configuration channel refused a write");

endmodule

bind quadratic_bspline_point_eval qbspe_checker u_qbspe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_x     (o_res.curve_x),
    .i_res_y     (o_res.curve_y),
    .i_cfg_ready (i_cfg.ready)
);

/* bench/quadratic_bspline_point_eval_tb.sv */
// Self-checking testbench for the quadratic B-spline point evaluator.
`timescale 1ns / 1ps

module quadratic_bspline_point_eval_tb;
    import qbspe_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 80;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          N_REGS = 2 * N_POINTS;
    localparam int          REPORT_LIMIT = 10;
    localparam int          RANDOM_PHASES = 10;
    localparam int          HOLD_PHASE = 3;

    localparam t_coord COORD_TOP    = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord COORD_BOTTOM = {1'b1, {(COORD_BITS-1){1'b0}}};

    class curve_point_checker;
        t_points ctrl_pts;
        t_point  expected_points[$];
        int      fails;

        function new();
            ctrl_pts = '0;
            fails = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_coord val);
            case (idx)
                REG_POINT0_X: ctrl_pts[0].x = val;
                REG_POINT0_Y: ctrl_pts[0].y = val;
                REG_POINT1_X: ctrl_pts[1].x = val;
                REG_POINT1_Y: ctrl_pts[1].y = val;
                REG_POINT2_X: ctrl_pts[2].x = val;
                REG_POINT2_Y: ctrl_pts[2].y = val;
                REG_POINT3_X: ctrl_pts[3].x = val;
                REG_POINT3_Y: ctrl_pts[3].y = val;
                default: ;
            endcase
        endfunction

        function t_coord mix_coord(t_coord c0, t_coord c1, t_coord c2,
                                   longint w0, longint w1, longint w2);
            longint acc;
            acc = longint'(c0) * w0 + longint'(c1) * w1 + longint'(c2) * w2;
            acc = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (acc > longint'(COORD_TOP)) acc = longint'(COORD_TOP);
            if (acc < longint'(COORD_BOTTOM)) acc = longint'(COORD_BOTTOM);
            return t_coord'(acc);
        endfunction

        function t_point eval_curve_point(t_param u_in);
            longint u, one_v, two_v, a, b, c, wa, wb, wc;
            t_point p0, p1, p2, res;
            one_v = longint'(U_ONE);
            two_v = longint'(U_TWO);
            u = longint'(u_in);
            if (u > two_v) u = two_v;
            if (u <= one_v) begin
                a  = one_v - u;
                wa = (a * a + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
                wb = ((u << (FRAC_BITS + 2)) - 3 * u * u + (longint'(1) << FRAC_BITS))
                     >>> (FRAC_BITS + 1);
                wc = (u * u + (longint'(1) << FRAC_BITS)) >>> (FRAC_BITS + 1);
                p0 = ctrl_pts[0];
                p1 = ctrl_pts[1];
                p2 = ctrl_pts[2];
            end else begin
                b  = two_v - u;
                c  = u - one_v;
                wa = (b * b + (longint'(1) << FRAC_BITS)) >>> (FRAC_BITS + 1);
                wb = ((longint'(1) << (2 * FRAC_BITS)) + (c << (FRAC_BITS + 1)) - 3 * c * c
                      + (longint'(1) << FRAC_BITS)) >>> (FRAC_BITS + 1);
                wc = (c * c + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
                p0 = ctrl_pts[1];
                p1 = ctrl_pts[2];
                p2 = ctrl_pts[3];
            end
            res.x = mix_coord(p0.x, p1.x, p2.x, wa, wb, wc);
            res.y = mix_coord(p0.y, p1.y, p2.y, wa, wb, wc);
            return res;
        endfunction

        function void note_param(t_param u);
            expected_points.push_back(eval_curve_point(u));
        endfunction

        function void flag(string field, t_coord want, t_coord got);
            fails++;
            if (fails <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
        endfunction

        function void check_point(t_coord x, t_coord y);
            t_point want;
            if (expected_points.size() == 0) begin
                fails++;
                if (fails <= REPORT_LIMIT)
                    $display("%0t: unexpected point (%0d, %0d)", $realtime, x, y);
                return;
            end
            want = expected_points.pop_front();
            if (want.x !== x) flag("curve_x", want.x, x);
            if (want.y !== y) flag("curve_y", want.y, y);
        endfunction

        function void close_out();
            if (expected_points.size() != 0) begin
                fails += expected_points.size();
                $display("%0d expected points never arrived", expected_points.size());
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        src_idle_en;
    logic        snk_idle_en;
    logic        hold_req;
    int unsigned cycles = 0;

    curve_point_checker chk;

    qbspe_in_if  in_if ();
    qbspe_out_if out_if ();
    qbspe_cfg_if cfg_if ();

    quadratic_bspline_point_eval uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_res   (out_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready)
            chk.check_point(out_if.curve_x, out_if.curve_y);
    end

    // The receiver stalls in short random bursts, and once for a long stretch on request.
    initial begin
        bit held;
        held = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !held) begin
                held = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            out_if.ready <= 1'b1;
        end
    end

    function automatic t_coord pick_coord();
        case ($urandom_range(0, 5))
            0: return COORD_TOP;
            1: return COORD_BOTTOM;
            2: return '0;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_param pick_param();
        case ($urandom_range(0, 9))
            0: return t_param'($urandom);
            1: return t_param'(U_ONE + $urandom_range(0, 4) - 2);
            2: return t_param'(U_TWO - $urandom_range(0, 3));
            3: return t_param'($urandom_range(0, 3));
            default: return t_param'($urandom_range(0, U_TWO));
        endcase
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input t_coord val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        chk.write_reg(idx, val);
    endtask

    task automatic load_points(input t_coord v [N_REGS]);
        for (int i = 0; i < N_REGS; i++)
            write_reg(t_cfg_idx'(REG_POINT0_X + i), v[i]);
        write_reg(t_cfg_idx'($urandom_range(REG_POINT3_Y + 1, (1 << CFG_IDX_BITS) - 1)),
                  t_coord'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_param(input t_param u);
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.param_u <= u;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        chk.note_param(u);
    endtask

    task automatic finish_batch();
        in_if.valid <= 1'b0;
        while (chk.expected_points.size() != 0) @(posedge clk);
    endtask

    initial begin
        t_param edge_params [12];
        t_param sat_params [6];
        t_coord pts [N_REGS];
        int     n_items;

        chk = new();
        rst_n         = 1'b0;
        src_idle_en   = 1'b1;
        snk_idle_en   = 1'b1;
        hold_req      = 1'b0;
        in_if.valid   = 1'b0;
        in_if.param_u = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;

        edge_params = '{16'd0, 16'd1, 16'd8192, 16'd16383, U_ONE, 16'd16385, 16'd24576,
                        16'd32767, U_TWO, 16'd32769, 16'hAAAA, 16'hFFFF};
        sat_params  = '{16'd0, 16'd5461, U_ONE, 16'd20000, 16'd27307, U_TWO};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_param(16'd0);
        send_param(U_TWO);
        finish_batch();

        pts = '{-16'sd16384, 16'sd8000, 16'sd12000, -16'sd20000,
                16'sd30000, 16'sd5, COORD_BOTTOM, COORD_TOP};
        load_points(pts);
        foreach (edge_params[i]) send_param(edge_params[i]);
        finish_batch();

        foreach (pts[i]) pts[i] = COORD_TOP;
        load_points(pts);
        foreach (sat_params[i]) send_param(sat_params[i]);
        finish_batch();

        foreach (pts[i]) pts[i] = COORD_BOTTOM;
        load_points(pts);
        foreach (sat_params[i]) send_param(sat_params[i]);
        finish_batch();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            foreach (pts[i]) pts[i] = pick_coord();
            load_points(pts);
            src_idle_en = (ph != RANDOM_PHASES - 1) && (ph != HOLD_PHASE);
            snk_idle_en = (ph != RANDOM_PHASES - 1);
            if (ph == HOLD_PHASE) hold_req = 1'b1;
            n_items = $urandom_range(60, 84);
            repeat (n_items) send_param(pick_param());
            finish_batch();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        chk.close_out();
        if (chk.fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
